/* rtl/core/dedup_key_set_macros.svh */
// Assertion macros shared by the key set RTL.
`ifndef DEDUP_KEY_SET_MACROS_SVH
`define DEDUP_KEY_SET_MACROS_SVH

// Same-cycle implication, checked at the rising edge of clk_i outside reset.
`define DKS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at the rising edge of clk_i outside reset.
`define DKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dks_pkg.sv */
// Package with constants and word types of the key set.
package dks_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned TOTAL_W      = 11;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key_word0;
    logic [KEY_W-1:0] key_word1;
    logic [KEY_W-1:0] key_word2;
    logic [KEY_W-1:0] key_word3;
  } in_word_t;

  typedef struct packed {
    logic               present;
    logic               added;
    logic               table_full;
    logic [TOTAL_W-1:0] entry_total;
  } out_word_t;

endpackage

/* rtl/core/dks_stream_if.sv */
// Valid/ready stream interface carrying one word per handshake.
interface dks_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/dedup_key_set.sv */
// Top level of the 256-bit key set with insert-if-absent and membership test.
//
// dedup_key_set keeps up to CAPACITY distinct 256-bit keys in one RAM and answers
// one command at a time: an add stores the key when it is absent and there is
// room, a test only reports presence, and both report the entry count afterwards.
// A command is accepted on in_i and scans the stored entries from entry 0, one
// RAM read per cycle, stopping at the first match. The scan time thus grows with
// the entry count, as the single RAM read port reads one entry at a time, and the
// next word can be taken in the cycle after the result is committed. The result
// waits in an output register, so a new word is taken while the previous result
// is pending.
// The key RAM needs no clearing after reset: only entries below the count are read.
`include "dedup_key_set_macros.svh"

module dedup_key_set #(
  parameter int unsigned CAPACITY = dks_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dks_stream_if.sink   in_i,
  dks_stream_if.source out_o
);
  import dks_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned ROW_W = 4 * KEY_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   addr_q, addr_d;
  logic               pend_q, pend_d;
  logic               found_q, found_d;
  logic               cmd_q;
  logic [ROW_W-1:0]   key_q;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_data_q;

  logic               issue;
  logic               hit;
  logic [ROW_W-1:0]   rdata;
  logic               accept;
  logic               commit;
  logic               do_add;
  logic               room;
  logic               mem_we;
  logic [CNT_W-1:0]   count_new;
  logic [TOTAL_W+CNT_W-1:0] total_ext;
  out_word_t          res;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign issue = (state_q == ST_SCAN) && (addr_q < count_q);
  assign hit   = pend_q && (rdata == key_q);

  assign room      = (count_q < CNT_W'(CAPACITY));
  assign do_add    = (cmd_q == CMD_ADD) && !found_q;
  assign commit    = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  assign mem_we    = commit && do_add && room;
  assign count_new = mem_we ? CNT_W'(count_q + 1'b1) : count_q;
  assign total_ext = {{TOTAL_W{1'b0}}, count_new};

  always_comb begin
    res.present     = found_q;
    res.added       = do_add && room;
    res.table_full  = do_add && !room;
    res.entry_total = total_ext[TOTAL_W-1:0];
  end

  dks_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (key_q),
    .re_i    (issue),
    .raddr_i (addr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    pend_d      = 1'b0;
    found_d     = found_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        addr_d = '0;
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || !issue) begin
          state_d = ST_DONE;
          found_d = hit;
        end else begin
          addr_d = CNT_W'(addr_q + 1'b1);
          pend_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_d     = ST_IDLE;
          count_d     = count_new;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_i.data.cmd;
      key_q <= {in_i.data.key_word3, in_i.data.key_word2,
                in_i.data.key_word1, in_i.data.key_word0};
    end
    if (commit) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  `DKS_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `DKS_ASSERT_IMPL(a_write_on_commit, mem_we, commit && !found_q, "key RAM written outside commit")
  `DKS_ASSERT_NEXT(a_add_counts, mem_we, count_q == CNT_W'($past(count_q) + 1'b1), "count not advanced on add")
  `DKS_ASSERT_NEXT(a_accept_scans, accept, state_q == ST_SCAN && addr_q == '0, "scan not started")

endmodule

/* rtl/core/dks_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dks_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
